// ----- hw/rtl/pcit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcit_pkg
// shared constants and command/status codes for the interpolation table
// ----------------------------------------------------------------------------
package pcit_pkg;

  localparam int MaxPoints = 64;
  localparam int ValueBits = 26;

  localparam int RangeLowReset  = -11796480;
  localparam int RangeHighReset = 11796480;

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdAdd    = 2'd1;
  localparam logic [1:0] CmdBase   = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  localparam logic [1:0] StCorrected = 2'd0;
  localparam logic [1:0] StNoSeg     = 2'd1;
  localparam logic [1:0] StUpdated   = 2'd2;
  localparam logic [1:0] StFull      = 2'd3;

  localparam logic [1:0] RegMinDist   = 2'd0;
  localparam logic [1:0] RegRangeLow  = 2'd1;
  localparam logic [1:0] RegRangeHigh = 2'd2;

endpackage : pcit_pkg
`default_nettype wire

// ----- hw/rtl/pointing_correction_interpolation_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pointing_correction_interpolation_table_unit
// sorted breakpoint table with linear interpolation, one axis
// ----------------------------------------------------------------------------
// One transaction at a time. The breakpoints live in one synchronous memory
// (position and value per entry) read one entry per cycle. A lookup walks
// the entries until it finds the segment and then runs a bit-serial
// rounding divider. Add point compacts the table while walking it and then
// shifts entries up one per cycle for the insert. After reset the default
// end points are written before the first transaction is taken.
module pointing_correction_interpolation_table_unit #(
  parameter int MAX_POINTS = pcit_pkg::MaxPoints,
  parameter int VALUE_BITS = pcit_pkg::ValueBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // cmd, position, manual_corr (from bit 0 up)
  input  wire logic [((2+2*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // status, corrected, manual_reset, base_value (from bit 0 up)
  output logic [((3+2*VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [VALUE_BITS-1:0] cfg_data_i
);

  localparam int W   = VALUE_BITS;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS+1);
  localparam int OWD = ((3+2*W+7)/8)*8;
  localparam int DW  = W + 2;             // difference width
  localparam int QCW = $clog2(2*DW+2);

  localparam logic [4:0] SIdle = 5'd0, SLkRd = 5'd1, SLkA = 5'd2, SLkB = 5'd3,
                         SDiv = 5'd4, SLkFin = 5'd5, SAdRd = 5'd6, SAdChk = 5'd7,
                         SInsChk = 5'd8, SShRd = 5'd9, SShWr = 5'd10, SInsWr = 5'd11,
                         SClr = 5'd12, SOut = 5'd13, SClrB = 5'd14;

  function automatic logic signed [W-1:0] sat_f(input logic signed [W+2:0] v);
    logic signed [W+2:0] hi, lo;
    hi = {4'b0, {(W-1){1'b1}}};
    lo = -hi - 1;
    if (v > hi) sat_f = hi[W-1:0];
    else if (v < lo) sat_f = lo[W-1:0];
    else sat_f = v[W-1:0];
  endfunction

  // memory
  logic [2*W-1:0] mem_q [MAX_POINTS];
  logic [AW-1:0]  raddr, waddr;
  logic           we;
  logic [2*W-1:0] wdata, rdata_q;
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end
  logic signed [W-1:0] rpos, rval;
  assign rpos = rdata_q[W-1:0];
  assign rval = rdata_q[2*W-1:W];

  // config
  logic [W-2:0] min_dist_q;
  logic signed [W-1:0] rlow_q, rhigh_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= '0;
      rlow_q <= W'(pcit_pkg::RangeLowReset);
      rhigh_q <= W'(pcit_pkg::RangeHighReset);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcit_pkg::RegMinDist:   min_dist_q <= cfg_data_i[W-2:0];
        pcit_pkg::RegRangeLow:  rlow_q <= cfg_data_i;
        pcit_pkg::RegRangeHigh: rhigh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state
  logic [4:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, w_q, w_d;
  logic signed [W-1:0] base_q, base_d, toff_q, toff_d, lpos_q, lpos_d;
  logic added_q, added_d, init_q, init_d;
  logic signed [W-1:0] pos_q, pos_d, man_q, man_d;
  logic signed [W-1:0] p0_q, p0_d, v0_q, v0_d, nv_q, nv_d;
  logic [DW-1:0] num_q, num_d, den_q, den_d, mag_q, mag_d, r_q, r_d;
  logic [2*DW-1:0] quo_q, quo_d;
  logic neg_q, neg_d;
  logic [QCW-1:0] dc_q, dc_d;
  logic [OWD-1:0] odata_q, odata_d;
  logic ovalid_q, ovalid_d;

  // divider step: shift remainder, add num if mag bit set, subtract den
  // up to twice (remainder below 3*den since num < den)
  logic [DW+1:0] rs, rs2;
  logic [1:0] qd;
  always_comb begin
    rs = {1'b0, r_q, 1'b0} + (mag_q[DW-1] ? {2'b0, num_q} : '0);
    if (rs >= {1'b0, den_q, 1'b0}) begin
      qd = 2'd2;
      rs2 = rs - {1'b0, den_q, 1'b0};
    end else if (rs >= {2'b0, den_q}) begin
      qd = 2'd1;
      rs2 = rs - {2'b0, den_q};
    end else begin
      qd = 2'd0;
      rs2 = rs;
    end
  end

  logic signed [W+2:0] addsum;
  assign addsum = (W+3)'(lpos_q) + (W+3)'(man_q) - (W+3)'(base_q) + (W+3)'(toff_q);

  logic signed [W:0] dd;
  logic [W:0] ad;
  assign dd = (W+1)'(rpos) - (W+1)'(lpos_q);
  assign ad = dd[W] ? (W+1)'(-dd) : (W+1)'(dd);

  assign s_axis_tready = (st_q == SIdle) && !ovalid_q && init_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  function automatic logic [OWD-1:0] pack_f(input logic [1:0] s, input logic [W-1:0] c,
                                            input logic m, input logic [W-1:0] b);
    pack_f = OWD'({b, m, c, s});
  endfunction

  always_comb begin
    logic signed [W+2:0] cw;
    logic signed [W-1:0] c;
    logic [2*DW-1:0] qr;
    cw = '0; c = '0; qr = '0;
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; w_d = w_q;
    base_d = base_q; toff_d = toff_q; lpos_d = lpos_q; added_d = added_q;
    init_d = init_q; pos_d = pos_q; man_d = man_q;
    p0_d = p0_q; v0_d = v0_q; nv_d = nv_q; num_d = num_q; den_d = den_q;
    mag_d = mag_q; r_d = r_q; quo_d = quo_q; neg_d = neg_q; dc_d = dc_q;
    odata_d = odata_q; ovalid_d = ovalid_q;
    raddr = i_q[AW-1:0]; waddr = '0; we = 1'b0; wdata = '0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (!init_q) begin
          st_d = SClr;
        end else if (s_axis_tvalid && !ovalid_q) begin
          pos_d = s_axis_tdata[2+W-1:2];
          man_d = s_axis_tdata[2+2*W-1:2+W];
          i_d = '0; w_d = '0;
          unique case (s_axis_tdata[1:0])
            pcit_pkg::CmdLookup: begin
              lpos_d = s_axis_tdata[2+W-1:2];
              st_d = (cnt_q < CW'(2)) ? SOut : SLkRd;
            end
            pcit_pkg::CmdAdd: begin
              st_d = (cnt_q == '0) ? SInsChk : SAdRd;
            end
            pcit_pkg::CmdBase: begin
              base_d = s_axis_tdata[2+2*W-1:2+W];
              st_d = SOut;
            end
            default: st_d = SClr;
          endcase
          odata_d = pack_f(pcit_pkg::StUpdated, '0, 1'b0, '0);
          if (s_axis_tdata[1:0] == pcit_pkg::CmdLookup)
            odata_d = pack_f(pcit_pkg::StNoSeg, '0, 1'b0, '0);
        end
      end
      SLkRd: begin
        raddr = i_q[AW-1:0];
        st_d = SLkA;
      end
      SLkA: begin
        p0_d = rpos; v0_d = rval;
        i_d = i_q + CW'(1);
        raddr = AW'(i_q + CW'(1));
        st_d = SLkB;
      end
      SLkB: begin
        if (pos_q >= p0_q && pos_q < rpos) begin
          num_d = DW'((W+1)'(pos_q) - (W+1)'(p0_q));
          den_d = DW'((W+1)'(rpos) - (W+1)'(p0_q));
          neg_d = rval < v0_q;
          mag_d = neg_d ? DW'((W+1)'(v0_q) - (W+1)'(rval))
                        : DW'((W+1)'(rval) - (W+1)'(v0_q));
          r_d = '0; quo_d = '0; dc_d = QCW'(DW);
          st_d = SDiv;
        end else if (i_q + CW'(1) >= cnt_q) begin
          st_d = SOut;
        end else begin
          p0_d = rpos; v0_d = rval;
          i_d = i_q + CW'(1);
          raddr = AW'(i_q + CW'(1));
          st_d = SLkB;
        end
      end
      SDiv: begin
        r_d = rs2[DW-1:0];
        quo_d = {quo_q[2*DW-2:0], 1'b0} + (2*DW)'(qd);
        mag_d = {mag_q[DW-2:0], 1'b0};
        dc_d = dc_q - QCW'(1);
        if (dc_q == QCW'(1)) st_d = SLkFin;
      end
      SLkFin: begin
        qr = quo_q + (({r_q, 1'b0} >= {1'b0, den_q}) ? (2*DW)'(1) : '0);
        cw = neg_q ? (W+3)'(v0_q) - (W+3)'(qr) : (W+3)'(v0_q) + (W+3)'(qr);
        c = sat_f(cw);
        toff_d = sat_f((W+3)'(c) - (W+3)'(pos_q));
        odata_d = pack_f(pcit_pkg::StCorrected, c, added_q, added_q ? base_q : '0);
        added_d = 1'b0;
        st_d = SOut;
      end
      SAdRd: begin
        raddr = i_q[AW-1:0];
        nv_d = sat_f(addsum);
        st_d = SAdChk;
      end
      SAdChk: begin
        if (ad >= (W+1)'(min_dist_q)) begin
          we = 1'b1; waddr = w_q[AW-1:0]; wdata = rdata_q;
          w_d = w_q + CW'(1);
        end
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) >= cnt_q) begin
          st_d = SInsChk;
        end else begin
          raddr = AW'(i_q + CW'(1));
          st_d = SAdChk;
        end
        if (i_q + CW'(1) >= cnt_q) begin
          cnt_d = (ad >= (W+1)'(min_dist_q)) ? w_q + CW'(1) : w_q;
        end
      end
      SInsChk: begin
        nv_d = sat_f(addsum);
        if (cnt_q >= CW'(MAX_POINTS)) begin
          odata_d = pack_f(pcit_pkg::StFull, '0, 1'b0, '0);
          st_d = SOut;
        end else if (cnt_q == '0) begin
          i_d = '0; st_d = SInsWr;
        end else begin
          i_d = cnt_q - CW'(1);
          raddr = AW'(cnt_q - CW'(1));
          st_d = SShWr;
        end
      end
      SShRd: begin
        raddr = AW'(i_q - CW'(1));
        st_d = SShWr;
      end
      SShWr: begin
        // current read is entry i_q
        if (rpos > lpos_q || (rpos == lpos_q && rval > nv_q)) begin
          we = 1'b1; waddr = AW'(i_q + CW'(1)); wdata = rdata_q;
          if (i_q == '0) begin
            st_d = SInsWr;
          end else begin
            i_d = i_q - CW'(1);
            raddr = AW'(i_q - CW'(1));
            st_d = SShWr;
          end
        end else begin
          i_d = i_q + CW'(1);
          st_d = SInsWr;
        end
      end
      SInsWr: begin
        we = 1'b1; waddr = i_q[AW-1:0]; wdata = {nv_q, lpos_q};
        cnt_d = cnt_q + CW'(1);
        added_d = 1'b1;
        st_d = SOut;
      end
      SClr: begin
        we = 1'b1; waddr = '0;
        wdata = (rlow_q > rhigh_q) ? {rhigh_q, rhigh_q} : {rlow_q, rlow_q};
        st_d = SClrB;
      end
      SClrB: begin
        we = 1'b1; waddr = AW'(1);
        wdata = (rlow_q > rhigh_q) ? {rlow_q, rlow_q} : {rhigh_q, rhigh_q};
        cnt_d = CW'(2);
        if (!init_q) begin
          init_d = 1'b1; st_d = SIdle;
        end else begin
          st_d = SOut;
        end
      end
      SOut: begin
        ovalid_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= CW'(2); base_q <= '0; toff_q <= '0; lpos_q <= '0;
      added_q <= 1'b0; init_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; base_q <= base_d; toff_q <= toff_d;
      lpos_q <= lpos_d; added_q <= added_d; init_q <= init_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; w_q <= w_d; pos_q <= pos_d; man_q <= man_d;
    p0_q <= p0_d; v0_q <= v0_d; nv_q <= nv_d; num_q <= num_d; den_q <= den_d;
    mag_q <= mag_d; r_q <= r_d; quo_q <= quo_d; neg_q <= neg_d; dc_q <= dc_d;
    odata_q <= odata_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS)) else $error("point count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SOut) |=> m_axis_tvalid) else $error("result missing");

endmodule : pointing_correction_interpolation_table_unit
`default_nettype wire
